[rtl/urx_pkg.sv]
// ----------------------------------------------------------------------------
// urx_pkg
// Shared widths, reset constants and control/status types for the UART
// receiver that decodes pulse-width captures.
// ----------------------------------------------------------------------------
package urx_pkg;

    localparam int CAP_W         = 16;   // capture and bit-width field width
    localparam int CHAR_W        = 8;    // width of the emitted character field
    localparam int CHAR_BITS_DEF = 8;    // data bits per frame
    localparam logic [CAP_W-1:0] BIT_WIDTH_RESET = 16'h0137;

    // Operation codes of an input request
    localparam logic OP_LOW    = 1'b0;   // low-pulse duration capture
    localparam logic OP_PERIOD = 1'b1;   // period capture, ends the high pulse

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;    // latch a new request and seed the divider
        logic step;    // run one divider iteration
        logic apply;   // commit the bit count to the frame state
    } urx_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_last;  // current divider iteration is the final one
        logic emit;      // committing now produces a character
    } urx_stat_t;

endpackage

[rtl/urx_in_if.sv]
// ----------------------------------------------------------------------------
// urx_in_if
// Capture request channel: operation code and captured timer count.
// ----------------------------------------------------------------------------
interface urx_in_if import urx_pkg::*; ();

    logic             valid;
    logic             ready;
    logic             operation;
    logic [CAP_W-1:0] capture_value;

    modport source (output valid, output operation, output capture_value, input ready);
    modport sink   (input valid, input operation, input capture_value, output ready);

endinterface

[rtl/urx_out_if.sv]
// ----------------------------------------------------------------------------
// urx_out_if
// Received character channel: data byte and idle-padding flag.
// ----------------------------------------------------------------------------
interface urx_out_if import urx_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_value;
    logic              padded;

    modport source (output valid, output char_value, output padded, input ready);
    modport sink   (input valid, input char_value, input padded, output ready);

endinterface

[rtl/uart_rx_from_pulse_widths.sv]
// ----------------------------------------------------------------------------
// uart_rx_from_pulse_widths
// UART receiver (8N1, LSB first) that rebuilds characters from timer
// pulse-width captures.
// ----------------------------------------------------------------------------
// Each request is one timer capture. A low-pulse capture (operation 0) is
// stored as the last low time and turned into zero bits, the duration divided
// by bit_width and rounded to nearest; a period capture (operation 1) minus
// the stored low time gives the high stretch, turned into one bits the same
// way (a period shorter than the low time counts as no bits, and a period
// while no frame is open is dropped). The first low pulse while idle opens a
// frame and gives up one bit as the start bit. Bits enter the shift word at
// the top, so the first data bit lands in bit 0 of char_value. A character is
// sent once CHAR_BITS bits are held (padded = 0), or when a long high supplies
// more ones than missing, in which case the tail is filled with ones and
// padded = 1. Too many zeros abort the frame silently. Each request passes
// through accept, the restoring divider (one quotient bit per cycle over the
// 17-bit rounded dividend) and the commit to the frame before the next one can
// be accepted; the commit waits only if a new character finds the previous one
// still untaken. A finished character waits in the output register while the
// next request is accepted. bit_width (reset 311 ticks, zero treated as one) is
// written through cfg_we/cfg_wdata and must only change while the receiver is
// idle.
// ----------------------------------------------------------------------------
module uart_rx_from_pulse_widths import urx_pkg::*; #(
    parameter int CHAR_BITS = CHAR_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    urx_in_if.sink           in_ch,
    urx_out_if.source        out_ch
);

    urx_cmd_t  cmd;
    urx_stat_t stat;

    // Sequence accept, divide, commit; own the output valid flag
    urx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Divider, frame state and character register
    urx_dpath #(
        .CHAR_BITS (CHAR_BITS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_operation     (in_ch.operation),
        .in_capture_value (in_ch.capture_value),
        .cmd              (cmd),
        .stat             (stat),
        .char_value       (out_ch.char_value),
        .padded           (out_ch.padded)
    );

endmodule

[rtl/urx_dpath.sv]
// ----------------------------------------------------------------------------
// urx_dpath
// Datapath: bit-width register, rounding divider (one quotient bit per
// cycle), frame shift word and the output character register.
// ----------------------------------------------------------------------------
module urx_dpath import urx_pkg::*; #(
    parameter int CHAR_BITS = CHAR_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CAP_W-1:0]  cfg_wdata,
    input  logic              in_operation,
    input  logic [CAP_W-1:0]  in_capture_value,
    input  urx_cmd_t          cmd,
    output urx_stat_t         stat,
    output logic [CHAR_W-1:0] char_value,
    output logic              padded
);

    localparam int DIV_W     = CAP_W + 1;
    localparam int DIV_STEPS = DIV_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int HELD_W    = $clog2(CHAR_BITS + 1);
    localparam int NB_W      = $clog2(CHAR_BITS + 3);
    localparam int SUM_W     = $clog2(2 * CHAR_BITS + 2);
    localparam int EXT_W     = (CHAR_BITS > CHAR_W) ? CHAR_BITS : CHAR_W;
    localparam logic [CHAR_BITS-1:0] ONES = '1;

    logic [CAP_W-1:0]     bw_reg;
    logic [CAP_W-1:0]     last_low_reg;
    logic                 op_reg;
    logic [DIV_W-1:0]     num_reg;
    logic [CAP_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 active_reg;
    logic [CHAR_BITS-1:0] word_reg;
    logic [HELD_W-1:0]    held_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic                 pad_reg;

    logic [CAP_W-1:0]     w_eff;
    logic [CAP_W-1:0]     dividend;
    logic [DIV_W-1:0]     trial;
    logic                 trial_ge;
    logic [NB_W-1:0]      q_sat;
    logic [NB_W-1:0]      n_eff;
    logic [SUM_W-1:0]     sum;
    logic                 over;
    logic                 full;
    logic                 take;
    logic                 drop;
    logic                 emit;
    logic [NB_W-1:0]      sh;
    logic [CHAR_BITS-1:0] shifted;
    logic [EXT_W-1:0]     ext_word;

    // A zero bit width behaves as one tick per bit
    assign w_eff = (bw_reg == '0) ? CAP_W'(1) : bw_reg;

    // Negative high time counts as zero ticks
    always_comb
    begin
        if (in_operation == OP_LOW)
        begin
            dividend = in_capture_value;
        end
        else if (in_capture_value >= last_low_reg)
        begin
            dividend = in_capture_value - last_low_reg;
        end
        else
        begin
            dividend = '0;
        end
    end

    assign trial    = {rem_reg, num_reg[DIV_W-1]};
    assign trial_ge = trial >= {1'b0, w_eff};

    // Any count beyond a full frame plus the start bit acts the same, so clamp it
    assign q_sat = (num_reg > DIV_W'(CHAR_BITS + 1)) ? NB_W'(CHAR_BITS + 2)
                                                     : NB_W'(num_reg);

    always_comb
    begin
        // The first low pulse of a frame carries the start bit
        if (op_reg == OP_LOW && !active_reg && q_sat != '0)
        begin
            n_eff = q_sat - NB_W'(1);
        end
        else
        begin
            n_eff = q_sat;
        end
    end

    assign sum  = SUM_W'(held_reg) + SUM_W'(n_eff);
    assign over = sum > SUM_W'(CHAR_BITS);
    assign full = sum == SUM_W'(CHAR_BITS);
    assign take = (op_reg == OP_LOW) || active_reg;
    assign drop = take && (op_reg == OP_LOW) && over;
    assign emit = take && (((op_reg == OP_PERIOD) && over) || (!over && full));

    // Long high pads only the bits still missing
    assign sh = over ? (NB_W'(CHAR_BITS) - NB_W'(held_reg)) : n_eff;
    assign shifted = (word_reg >> sh) | ((op_reg == OP_PERIOD) ? ~(ONES >> sh) : '0);
    assign ext_word = EXT_W'(shifted);

    assign stat.div_last = cnt_reg == CNT_W'(DIV_STEPS - 1);
    assign stat.emit     = emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg       <= BIT_WIDTH_RESET;
            last_low_reg <= '0;
            active_reg   <= 1'b0;
            word_reg     <= '0;
            held_reg     <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                bw_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                cnt_reg <= '0;
                if (in_operation == OP_LOW)
                begin
                    last_low_reg <= in_capture_value;
                end
            end
            else if (cmd.step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.apply && take)
            begin
                if (emit || drop)
                begin
                    active_reg <= 1'b0;
                    word_reg   <= '0;
                    held_reg   <= '0;
                end
                else
                begin
                    active_reg <= 1'b1;
                    word_reg   <= shifted;
                    held_reg   <= HELD_W'(sum);
                end
            end
        end
    end

    // Divider and output payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_operation;
            num_reg <= {1'b0, dividend} + {2'b00, w_eff[CAP_W-1:1]};
            rem_reg <= '0;
        end
        else if (cmd.step)
        begin
            num_reg <= {num_reg[DIV_W-2:0], trial_ge};
            rem_reg <= trial_ge ? CAP_W'(trial - {1'b0, w_eff}) : CAP_W'(trial);
        end
        if (cmd.apply && emit)
        begin
            char_reg <= ext_word[CHAR_W-1:0];
            pad_reg  <= (op_reg == OP_PERIOD) && over;
        end
    end

    assign char_value = char_reg;
    assign padded     = pad_reg;

endmodule

[rtl/urx_ctrl.sv]
// ----------------------------------------------------------------------------
// urx_ctrl
// Controller: sequences accept, divide and commit for each request and
// owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module urx_ctrl import urx_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  urx_stat_t stat,
    output urx_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_DIV   = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                // Hold while a new character would overwrite a pending one
                if (!stat.emit || slot_free)
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.apply && stat.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply && stat.emit) |-> (!out_valid_reg || out_ready))
        else $error("character committed over a pending one");

    a_load_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_DIV))
        else $error("accepted request did not start the divider");

    a_div_to_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && stat.div_last) |=> (state_reg == S_APPLY))
        else $error("divider end did not lead to commit");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.apply && stat.emit))
        else $error("output valid rose without a committed character");
`endif

endmodule
